// File: rtl/k_nearest_insertion_list_assert.svh
// Assertion macros for the nearest-candidate list.
// Included by the top level; depends on nothing else.
`ifndef K_NEAREST_INSERTION_LIST_ASSERT_SVH
`define K_NEAREST_INSERTION_LIST_ASSERT_SVH

`ifndef ASSERT_OFF
`define KNIL_ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);
`define KNIL_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);
`else
`define KNIL_ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg)
`define KNIL_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif

`endif

// File: rtl/knil_pkg.sv
// Shared types and constants of the nearest-candidate list.
// Used by knil_cell and k_nearest_insertion_list; depends on nothing.
package knil_pkg;

	localparam int MAX_KEPT_DEF = 8;
	localparam int KC_W = 5;
	localparam logic [KC_W-1:0] KEPT_RESET = 5'd6;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [0:0] REG_KEPT_COUNT = 1'b0;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_DUMP = 2'd2;

	localparam logic [31:0] EMPTY_DIST = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] candidate_index;
		logic [31:0] distance;
	} in_item_t;

	typedef struct packed {
		logic [15:0] slot_index;
		logic [31:0] slot_distance;
		logic        slot_valid;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [31:0] distance;
		logic [15:0] index;
		logic        valid;
	} slot_t;

	typedef struct packed {
		logic clear;
		logic insert;
		logic live;
	} cell_ctrl_t;

	localparam slot_t EMPTY_SLOT = '{distance: EMPTY_DIST, index: 16'd0, valid: 1'b0};

endpackage

// File: rtl/knil_cell.sv
// One slot of the sorted list: compares the candidate with its own entry
// and takes the candidate, its upper neighbor's entry, holds, or empties itself. Uses knil_pkg.
module knil_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  knil_pkg::cell_ctrl_t ctrl,
	input  knil_pkg::slot_t    new_slot,
	input  knil_pkg::slot_t    prev_slot,
	input  logic               found_in,
	output logic               found_out,
	output knil_pkg::slot_t    slot
);

	knil_pkg::slot_t slot_q;
	logic ge;

	// The candidate belongs at or above this slot once the slot is empty
	// or holds a distance not below the candidate's.
	assign ge = !slot_q.valid || (slot_q.distance >= new_slot.distance);
	assign found_out = found_in | ge;
	assign slot = slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= knil_pkg::EMPTY_SLOT;
		end else if (ctrl.clear) begin
			slot_q <= knil_pkg::EMPTY_SLOT;
		end else if (ctrl.insert) begin
			if (!ctrl.live) begin
				slot_q <= knil_pkg::EMPTY_SLOT;
			end else if (found_in) begin
				slot_q <= prev_slot;
			end else if (ge) begin
				slot_q <= new_slot;
			end
		end
	end

endmodule

// File: rtl/k_nearest_insertion_list.sv
// Nearest-candidate list: a row of knil_cell slots kept sorted by ascending
// distance. Depends on knil_pkg and k_nearest_insertion_list_assert.svh.
//
// A clear or an insert never stalls the input; every slot compares the
// candidate in parallel and shifts toward its lower neighbor. A dump stalls
// the input and emits one slot per cycle through the output register while
// the output does not stall; the input stays stalled until the last of depth
// slots is loaded (depth is kept_count limited to 1..MAX_KEPT). Reset empties
// every slot at once; there is no clearing pass.
`include "k_nearest_insertion_list_assert.svh"

module k_nearest_insertion_list #(
	parameter int MAX_KEPT = knil_pkg::MAX_KEPT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  knil_pkg::in_item_t                  in_item,
	output logic                                out_valid,
	input  logic                                out_stall,
	output knil_pkg::out_item_t                 out_item,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [knil_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [knil_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [knil_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready
);

	localparam int CNT_W = $clog2(MAX_KEPT + 1);
	localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DUMP = 2'b10
	} state_t;

	state_t state_q;
	logic [knil_pkg::KC_W-1:0] kept_count_q;
	logic [IDX_W-1:0] cnt_q;
	logic out_valid_q;
	knil_pkg::out_item_t out_q;

	logic accept;
	logic load;
	logic cnt_last;
	logic cfg_wr;
	logic [CNT_W-1:0] depth;
	logic [MAX_KEPT-1:0] valid_vec;
	knil_pkg::slot_t new_slot;
	knil_pkg::slot_t slots [MAX_KEPT];
	logic found [MAX_KEPT+1];

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		case (paddr[knil_pkg::CFG_ADDR_W-1:2])
			knil_pkg::REG_KEPT_COUNT: prdata = knil_pkg::CFG_DATA_W'(kept_count_q);
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_count_q <= knil_pkg::KEPT_RESET;
		end else if (cfg_wr && paddr[knil_pkg::CFG_ADDR_W-1:2] == knil_pkg::REG_KEPT_COUNT) begin
			kept_count_q <= pwdata[knil_pkg::KC_W-1:0];
		end
	end

	// Effective depth: zero acts as one, anything above the built row is capped.
	always_comb begin
		if (kept_count_q == '0) begin
			depth = CNT_W'(1);
		end else if (kept_count_q > knil_pkg::KC_W'(MAX_KEPT)) begin
			depth = CNT_W'(MAX_KEPT);
		end else begin
			depth = CNT_W'(kept_count_q);
		end
	end

	assign in_stall = (state_q == ST_DUMP);
	assign accept = in_valid && !in_stall;

	assign new_slot = '{distance: in_item.distance, index: in_item.candidate_index,
		valid: 1'b1};
	assign found[0] = 1'b0;

	for (genvar k = 0; k < MAX_KEPT; k++) begin : g_cell
		knil_pkg::cell_ctrl_t ctrl;
		knil_pkg::slot_t prev;

		assign ctrl.clear = accept && (in_item.opcode == knil_pkg::OP_CLEAR);
		assign ctrl.insert = accept && (in_item.opcode == knil_pkg::OP_INSERT);
		assign ctrl.live = (CNT_W'(k) < depth);
		if (k == 0) begin : g_head
			assign prev = knil_pkg::EMPTY_SLOT;
		end else begin : g_body
			assign prev = slots[k-1];
		end

		knil_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.new_slot  (new_slot),
			.prev_slot (prev),
			.found_in  (found[k]),
			.found_out (found[k+1]),
			.slot      (slots[k])
		);

		assign valid_vec[k] = slots[k].valid;
	end

	// Dump sequencer: loads one slot into the output register per free cycle.
	assign load = (state_q == ST_DUMP) && (!out_valid_q || !out_stall);
	assign cnt_last = (CNT_W'(cnt_q) == depth - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && in_item.opcode == knil_pkg::OP_DUMP) begin
						state_q <= ST_DUMP;
						cnt_q <= '0;
					end
				end
				ST_DUMP: begin
					if (load) begin
						if (cnt_last) begin
							state_q <= ST_IDLE;
						end
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.slot_index <= slots[cnt_q].index;
			out_q.slot_distance <= slots[cnt_q].distance;
			out_q.slot_valid <= slots[cnt_q].valid;
			out_q.last <= cnt_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

	// Occupied slots always form an unbroken run from the head of the row.
	`KNIL_ASSERT_IMPLIES(a_valid_prefix, clk, arst_n, 1'b1,
		(valid_vec & (valid_vec + MAX_KEPT'(1))) == '0, "occupied slots are not contiguous")
	`KNIL_ASSERT_NEXT(a_dump_starts, clk, arst_n,
		accept && in_item.opcode == knil_pkg::OP_DUMP, state_q == ST_DUMP,
		"dump transaction did not start the sequencer")
	`KNIL_ASSERT_NEXT(a_dump_ends, clk, arst_n, load && cnt_last,
		state_q == ST_IDLE && out_valid && out_item.last, "dump did not end on the final slot")

endmodule

// File: dv/tb_k_nearest_insertion_list.sv
// Testbench for k_nearest_insertion_list: random and directed clear, insert and dump
// transactions, checked against a sorted-list predictor kept in the bench.
// Depends on knil_pkg and the k_nearest_insertion_list RTL.
`timescale 1ns / 1ps

module tb_k_nearest_insertion_list;

	localparam int LIST_DEPTH = knil_pkg::MAX_KEPT_DEF;
	localparam int NUM_PHASES = 10;
	localparam int ITEMS_PER_PHASE = 34;
	localparam int SETTLE_CYCLES = 2 * LIST_DEPTH + 8;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [knil_pkg::CFG_ADDR_W-1:0] KEPT_COUNT_ADDR =
		{knil_pkg::REG_KEPT_COUNT, 2'b00};
	localparam logic [knil_pkg::CFG_ADDR_W-1:0] UNUSED_REG_ADDR = 3'd4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	knil_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	knil_pkg::out_item_t out_item;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [knil_pkg::CFG_ADDR_W-1:0] paddr = '0;
	logic [knil_pkg::CFG_DATA_W-1:0] pwdata = '0;
	logic [knil_pkg::CFG_DATA_W-1:0] prdata;
	logic pready;

	knil_pkg::in_item_t pending_items[$];
	knil_pkg::out_item_t expected_slots[$];
	knil_pkg::slot_t list_slots [LIST_DEPTH];
	logic [knil_pkg::KC_W-1:0] kept_count_model = knil_pkg::KEPT_RESET;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int queued_items = 0;
	int error_count = 0;

	k_nearest_insertion_list dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("tb_k_nearest_insertion_list: errors");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		error_count++;
	endtask

	// The depth in use: zero acts as one, anything past the built depth is clipped.
	function automatic int active_depth();
		int d;
		d = int'(kept_count_model);
		if (d == 0) d = 1;
		if (d > LIST_DEPTH) d = LIST_DEPTH;
		return d;
	endfunction

	task automatic insert_candidate(input logic [15:0] idx, input logic [31:0] cand_dist);
		int n;
		int pos;
		int k;
		n = active_depth();
		pos = 0;
		while (pos < n && list_slots[pos].valid && list_slots[pos].distance < cand_dist)
			pos++;
		if (pos < n) begin
			for (k = n - 1; k > pos; k--)
				list_slots[k] = list_slots[k - 1];
			list_slots[pos] = '{distance: cand_dist, index: idx, valid: 1'b1};
		end
		for (k = n; k < LIST_DEPTH; k++)
			list_slots[k] = knil_pkg::EMPTY_SLOT;
	endtask

	task automatic expect_dump();
		int n;
		int k;
		knil_pkg::out_item_t slot_item;
		n = active_depth();
		for (k = 0; k < n; k++) begin
			slot_item = '{slot_index: list_slots[k].index,
				slot_distance: list_slots[k].distance,
				slot_valid: list_slots[k].valid, last: (k == n - 1)};
			expected_slots = {expected_slots, slot_item};
		end
	endtask

	// Predictor: follows accepted transactions and register writes at the clock edge.
	initial begin
		for (int k = 0; k < LIST_DEPTH; k++)
			list_slots[k] = knil_pkg::EMPTY_SLOT;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				case (in_item.opcode)
					knil_pkg::OP_CLEAR: begin
						for (int k = 0; k < LIST_DEPTH; k++)
							list_slots[k] = knil_pkg::EMPTY_SLOT;
					end
					knil_pkg::OP_INSERT:
						insert_candidate(in_item.candidate_index, in_item.distance);
					knil_pkg::OP_DUMP: expect_dump();
					default: ;
				endcase
			end
			if (psel && penable && pwrite && pready && paddr == KEPT_COUNT_ADDR)
				kept_count_model = pwdata[knil_pkg::KC_W-1:0];
		end
	end

	// Driver: presents the next pending item once the current one has been taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_item <= pending_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Monitor: each output transaction is matched against the oldest expected slot.
	always @(posedge clk) begin : slot_monitor
		knil_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_slots.size() == 0) begin
				report_mismatch($sformatf("unexpected slot: index %h distance %h valid %b last %b",
					out_item.slot_index, out_item.slot_distance, out_item.slot_valid,
					out_item.last));
			end else begin
				want = expected_slots.pop_front();
				if (out_item.slot_index !== want.slot_index)
					report_mismatch($sformatf("slot_index %h, expected %h",
						out_item.slot_index, want.slot_index));
				if (out_item.slot_distance !== want.slot_distance)
					report_mismatch($sformatf("slot_distance %h, expected %h",
						out_item.slot_distance, want.slot_distance));
				if (out_item.slot_valid !== want.slot_valid)
					report_mismatch($sformatf("slot_valid %b, expected %b",
						out_item.slot_valid, want.slot_valid));
				if (out_item.last !== want.last)
					report_mismatch($sformatf("last %b, expected %b", out_item.last, want.last));
			end
		end
	end

	task automatic add_item(input logic [1:0] op, input logic [15:0] idx,
			input logic [31:0] cand_dist);
		knil_pkg::in_item_t item;
		item = '{opcode: op, candidate_index: idx, distance: cand_dist};
		pending_items = {pending_items, item};
		if (op != OP_UNUSED) queued_items++;
	endtask

	// Small values give plenty of ties; the extremes show up often on their own.
	function automatic logic [31:0] pick_distance();
		case ($urandom_range(9))
			0: return 32'd0;
			1: return knil_pkg::EMPTY_DIST;
			2: return knil_pkg::EMPTY_DIST - $urandom_range(2);
			3, 4: return $urandom_range(7);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_index();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	task automatic add_random_burst();
		int pick;
		int n;
		pick = $urandom_range(9);
		if (pick < 7) begin
			if ($urandom_range(3) != 0)
				add_item(knil_pkg::OP_CLEAR, pick_index(), pick_distance());
			n = $urandom_range(12);
			for (int k = 0; k < n; k++)
				add_item(knil_pkg::OP_INSERT, pick_index(), pick_distance());
			add_item(knil_pkg::OP_DUMP, pick_index(), pick_distance());
		end else if (pick == 7) begin
			add_item(knil_pkg::OP_DUMP, pick_index(), pick_distance());
		end else begin
			n = $urandom_range(4, 1);
			for (int k = 0; k < n; k++)
				add_item(2'($urandom_range(3)), pick_index(), pick_distance());
		end
	endtask

	task automatic write_reg(input logic [knil_pkg::CFG_ADDR_W-1:0] addr,
			input logic [knil_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Clears and inserts give no result, so the block gets a settling pause of SETTLE_CYCLES.
	task automatic wait_idle();
		while (pending_items.size() != 0 || in_valid || expected_slots.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [knil_pkg::KC_W-1:0] kept_plan [NUM_PHASES];
		int target;
		kept_plan = '{knil_pkg::KEPT_RESET, 5'd1, 5'd16, 5'd3, 5'd0, 5'd31, 5'd8, 5'd2,
			5'd7, 5'd4};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p < 4) begin
				send_idle_pct = 18;
				recv_idle_pct = 65;
			end else if (p < 7) begin
				send_idle_pct = 65;
				recv_idle_pct = 18;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (p == 0) begin
				// Directed opening at the reset depth of six.
				add_item(knil_pkg::OP_DUMP, 16'h0000, 32'h0);
				add_item(knil_pkg::OP_INSERT, 16'hFFFF, knil_pkg::EMPTY_DIST);
				add_item(knil_pkg::OP_INSERT, 16'h0000, 32'h0);
				add_item(knil_pkg::OP_INSERT, 16'd5, 32'd100);
				add_item(knil_pkg::OP_INSERT, 16'd6, 32'd100);
				add_item(knil_pkg::OP_DUMP, 16'hFFFF, knil_pkg::EMPTY_DIST);
				add_item(knil_pkg::OP_INSERT, 16'd7, 32'd50);
				add_item(knil_pkg::OP_INSERT, 16'd8, 32'd200);
				add_item(knil_pkg::OP_INSERT, 16'd9, knil_pkg::EMPTY_DIST);
				add_item(knil_pkg::OP_INSERT, 16'd10, 32'd1);
				add_item(knil_pkg::OP_DUMP, 16'h0, 32'h0);
				add_item(OP_UNUSED, 16'hAAAA, 32'h5555_5555);
				add_item(OP_UNUSED, 16'h5555, 32'hAAAA_AAAA);
				add_item(knil_pkg::OP_DUMP, 16'h0, 32'h0);
				add_item(knil_pkg::OP_CLEAR, 16'hFFFF, knil_pkg::EMPTY_DIST);
				add_item(knil_pkg::OP_DUMP, 16'h0, 32'h0);
				add_item(knil_pkg::OP_INSERT, 16'hAAAA, 32'hAAAA_AAAA);
				add_item(knil_pkg::OP_INSERT, 16'h5555, 32'h5555_5555);
				add_item(knil_pkg::OP_DUMP, 16'h0, 32'h0);
			end else begin
				// New depth without a clear; the leading dump shows what survived.
				wait_idle();
				if (p == 5) write_reg(UNUSED_REG_ADDR, $urandom);
				write_reg(KEPT_COUNT_ADDR, knil_pkg::CFG_DATA_W'(kept_plan[p]));
				add_item(knil_pkg::OP_DUMP, pick_index(), pick_distance());
			end
			target = queued_items + ITEMS_PER_PHASE;
			while (queued_items < target)
				add_random_burst();
		end
		wait_idle();
		if (error_count == 0)
			$display("tb_k_nearest_insertion_list: clean");
		else
			$display("tb_k_nearest_insertion_list: errors");
		$finish;
	end

endmodule
